FILE: rtl/spectrum_peak_smoother_bar_mapper_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef SPECTRUM_PEAK_SMOOTHER_BAR_MAPPER_UNIT_MACROS_SVH
`define SPECTRUM_PEAK_SMOOTHER_BAR_MAPPER_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SPSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define SPSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spsb_pkg.sv
package spsb_pkg;

  localparam int NUM_BINS_DEF        = 128;
  localparam int DISPLAY_COLUMNS_DEF = 128;

  // Item kinds.
  localparam logic [1:0] KIND_UPDATE     = 2'd0;
  localparam logic [1:0] KIND_QUERY      = 2'd1;
  localparam logic [1:0] KIND_INVALIDATE = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_ORIGIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_MAX_HEIGHT   = 3'd5;

  localparam int CFG_DATA_W = 20;

  // Register reset values.
  localparam logic [19:0] RST_BIN_ORIGIN       = 20'd1092;
  localparam logic [19:0] RST_BIN_STEP         = 20'd1368;
  localparam logic [15:0] RST_ATTACK_GAIN      = 16'd19661;
  localparam logic [15:0] RST_DECAY_GAIN       = 16'd60293;
  localparam logic [11:0] RST_INTERP_THRESHOLD = 12'd40;
  localparam logic [7:0]  RST_BAR_MAX_HEIGHT   = 8'd54;

  // One in Q0.12, as a weight.
  localparam logic [12:0] FRAC_ONE = 13'd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_wr;
    logic rd_upd;
    logic mul_upd;
    logic wr_upd;
    logic mul_pos;
    logic rd_lo;
    logic rd_hi;
    logic mul_lo;
    logic mul_hi;
    logic mul_bar;
    logic load_out;
  } spsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } spsb_stat_t;

endpackage

FILE: rtl/spectrum_peak_smoother_bar_mapper_unit.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    kind, bin, magnitude, frame_end, column
// out      out_valid / out_ready  smoothed, bar_pixels, spectrum_ready
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input transaction yields exactly one output transaction. One item is
// worked at a time on the single store port and the shared multiplier. After
// reset the store is cleared one bin per cycle, with in_ready low. A result
// waiting in the output register does not stop a new item from being taken;
// only the final load waits on out_ready.

module spectrum_peak_smoother_bar_mapper_unit import spsb_pkg::*; #(
  parameter int NUM_BINS        = NUM_BINS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [6:0]            bin,
  input  logic [15:0]           magnitude,
  input  logic                  frame_end,
  input  logic [6:0]            column,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           smoothed,
  output logic [7:0]            bar_pixels,
  output logic                  spectrum_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration writes land directly in the registers, so the port is always open.
  assign cfg_ready = 1'b1;

  spsb_cmd_t  cmd;
  spsb_stat_t stat;

  // The controller sequences reads, multiplies and the store write-back.
  spsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the store and the shared multiplier.
  spsb_datapath #(
    .NUM_BINS        (NUM_BINS),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .bin            (bin),
    .magnitude      (magnitude),
    .frame_end      (frame_end),
    .column         (column),
    .cmd            (cmd),
    .stat           (stat),
    .smoothed       (smoothed),
    .bar_pixels     (bar_pixels),
    .spectrum_ready (spectrum_ready)
  );

endmodule

FILE: rtl/spsb_ctrl.sv
module spsb_ctrl import spsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  output logic       out_valid,
  input  logic       out_ready,
  input  spsb_stat_t stat,
  output spsb_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_U_RD   = 4'd2;
  localparam logic [3:0] S_U_MUL  = 4'd3;
  localparam logic [3:0] S_U_WR   = 4'd4;
  localparam logic [3:0] S_Q_POS  = 4'd5;
  localparam logic [3:0] S_Q_RDLO = 4'd6;
  localparam logic [3:0] S_Q_RDHI = 4'd7;
  localparam logic [3:0] S_Q_MIX  = 4'd8;
  localparam logic [3:0] S_Q_BAR  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (kind)
            KIND_UPDATE: state_next = S_U_RD;
            KIND_QUERY:  state_next = S_Q_POS;
            default:     state_next = S_FIN;
          endcase
        end
      end
      S_U_RD: begin
        cmd.rd_upd = 1'b1;
        state_next = S_U_MUL;
      end
      S_U_MUL: begin
        cmd.mul_upd = 1'b1;
        state_next  = S_U_WR;
      end
      S_U_WR: begin
        cmd.wr_upd = 1'b1;
        state_next = S_FIN;
      end
      S_Q_POS: begin
        cmd.mul_pos = 1'b1;
        state_next  = S_Q_RDLO;
      end
      S_Q_RDLO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_Q_RDHI;
      end
      S_Q_RDHI: begin
        cmd.rd_hi  = 1'b1;
        cmd.mul_lo = 1'b1;
        state_next = S_Q_MIX;
      end
      S_Q_MIX: begin
        cmd.mul_hi = 1'b1;
        state_next = S_Q_BAR;
      end
      S_Q_BAR: begin
        cmd.mul_bar = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/spsb_datapath.sv
module spsb_datapath import spsb_pkg::*; #(
  parameter int NUM_BINS        = NUM_BINS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            kind,
  input  logic [6:0]            bin,
  input  logic [15:0]           magnitude,
  input  logic                  frame_end,
  input  logic [6:0]            column,
  input  spsb_cmd_t             cmd,
  output spsb_stat_t            stat,
  output logic [15:0]           smoothed,
  output logic [7:0]            bar_pixels,
  output logic                  spectrum_ready
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0] LastBin  = AW'(NUM_BINS - 1);
  localparam logic [31:0]   NumBinsU = 32'(NUM_BINS);
  localparam logic [31:0]   NumColsU = 32'(DISPLAY_COLUMNS);

  // Configuration registers.
  logic [19:0] bin_origin;
  logic [19:0] bin_step;
  logic [15:0] attack_gain;
  logic [15:0] decay_gain;
  logic [11:0] interp_threshold;
  logic [7:0]  bar_max_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_origin       <= RST_BIN_ORIGIN;
      bin_step         <= RST_BIN_STEP;
      attack_gain      <= RST_ATTACK_GAIN;
      decay_gain       <= RST_DECAY_GAIN;
      interp_threshold <= RST_INTERP_THRESHOLD;
      bar_max_height   <= RST_BAR_MAX_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIN_ORIGIN:       bin_origin       <= cfg_data;
        REG_BIN_STEP:         bin_step         <= cfg_data;
        REG_ATTACK_GAIN:      attack_gain      <= cfg_data[15:0];
        REG_DECAY_GAIN:       decay_gain       <= cfg_data[15:0];
        REG_INTERP_THRESHOLD: interp_threshold <= cfg_data[11:0];
        REG_BAR_MAX_HEIGHT:   bar_max_height   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]  kind_q;
  logic [6:0]  bin_q;
  logic [15:0] mag_q;
  logic        fe_q;
  logic [6:0]  col_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q <= kind;
      bin_q  <= bin;
      mag_q  <= magnitude;
      fe_q   <= frame_end;
      col_q  <= column;
    end
  end

  logic bin_ok;
  logic col_ok;
  assign bin_ok = 32'(bin_q) < NumBinsU;
  assign col_ok = 32'(col_q) < NumColsU;

  // Smoothed magnitude store with one shared port and registered read data.
  logic [15:0]   store [NUM_BINS];
  logic [15:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [AW-1:0] clr_cnt;

  // Working registers.
  logic [27:0] pos_q;
  logic [31:0] acc_q;
  logic        rising_q;
  logic [15:0] blend_q;
  logic [15:0] sm_q;
  logic [7:0]  bar_q;
  logic        frame_valid;

  // Bin position decode.
  logic [15:0]   lo;
  logic [11:0]   frac;
  logic          lo_in;
  logic          has_hi;
  logic          interp;
  logic [AW-1:0] lo_sel;
  logic [AW-1:0] hi_sel;
  logic [12:0]   frac_eff;
  logic [12:0]   w_lo;

  assign lo       = pos_q[27:12];
  assign frac     = pos_q[11:0];
  assign lo_in    = 32'(lo) < NumBinsU;
  assign has_hi   = (32'(lo) + 32'd1) < NumBinsU;
  assign interp   = lo_in && has_hi && (frac > interp_threshold);
  assign lo_sel   = lo_in ? AW'(lo) : LastBin;
  assign hi_sel   = interp ? AW'(lo_sel + 1'b1) : lo_sel;
  assign frac_eff = interp ? {1'b0, frac} : 13'd0;
  assign w_lo     = FRAC_ONE - frac_eff;

  // Shared multiplier.
  logic        rising;
  logic [19:0] mul_a;
  logic [15:0] mul_b;
  logic [35:0] prod;

  assign rising = mag_q > rdata;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_pos) begin
      mul_a = bin_step;
      mul_b = {9'd0, col_q};
    end else if (cmd.mul_upd) begin
      mul_a = rising ? {4'd0, 16'(mag_q - rdata)} : {4'd0, rdata};
      mul_b = rising ? attack_gain : decay_gain;
    end else if (cmd.mul_lo) begin
      mul_a = {4'd0, rdata};
      mul_b = {3'd0, w_lo};
    end else if (cmd.mul_hi) begin
      mul_a = {4'd0, rdata};
      mul_b = {3'd0, frac_eff};
    end else if (cmd.mul_bar) begin
      mul_a = {4'd0, blend_q};
      mul_b = {8'd0, bar_max_height};
    end
  end

  assign prod = 36'(mul_a) * 36'(mul_b);

  // New smoothed value once the scaled term is in acc_q.
  logic [15:0] scaled;
  logic [15:0] sm_val;
  logic [27:0] mix_sum;
  logic [9:0]  h_raw;

  assign scaled  = acc_q[31:16];
  assign sm_val  = rising_q ? 16'(rdata + scaled) : ((scaled > mag_q) ? scaled : mag_q);
  assign mix_sum = acc_q[27:0] + prod[27:0];
  assign h_raw   = prod[23:14];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sm_q  <= '0;
      bar_q <= '0;
    end else if (cmd.mul_pos) begin
      pos_q <= 28'(bin_origin) + prod[27:0];
    end else if (cmd.mul_upd) begin
      acc_q    <= prod[31:0];
      rising_q <= rising;
    end else if (cmd.wr_upd) begin
      sm_q <= bin_ok ? sm_val : 16'd0;
    end else if (cmd.mul_lo) begin
      acc_q <= prod[31:0];
    end else if (cmd.mul_hi) begin
      blend_q <= mix_sum[27:12];
    end else if (cmd.mul_bar) begin
      if (!col_ok) begin
        bar_q <= 8'd0;
      end else if (h_raw > {2'b00, bar_max_height}) begin
        bar_q <= bar_max_height;
      end else begin
        bar_q <= h_raw[7:0];
      end
    end
  end

  // Memory port muxing.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.wr_upd && bin_ok) begin
      we    = 1'b1;
      waddr = AW'(bin_q);
      wdata = sm_val;
    end
  end

  assign rd_en = cmd.rd_upd | cmd.rd_lo | cmd.rd_hi;

  always_comb begin
    if (cmd.rd_upd) begin
      raddr = AW'(bin_q);
    end else if (cmd.rd_lo) begin
      raddr = lo_sel;
    end else begin
      raddr = hi_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clr_last = clr_cnt == LastBin;

  // Frame valid flag and result register.
  logic fv_next;

  always_comb begin
    fv_next = frame_valid;
    if (kind_q == KIND_UPDATE && fe_q) begin
      fv_next = 1'b1;
    end else if (kind_q == KIND_INVALIDATE) begin
      fv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (cmd.load_out) begin
      frame_valid <= fv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      smoothed       <= sm_q;
      bar_pixels     <= bar_q;
      spectrum_ready <= fv_next;
    end
  end

endmodule

FILE: rtl/spsb_checker.sv
`include "spectrum_peak_smoother_bar_mapper_unit_macros.svh"

module spsb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] smoothed,
  input logic [7:0]  bar_pixels,
  input logic        spectrum_ready
);

  // A stalled result must hold its payload.
  `SPSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(smoothed) && $stable(bar_pixels) && $stable(spectrum_ready),
    "output changed while stalled")

  // An item is either an update or a query, never both.
  `SPSB_ASSERT_SAME(a_one_result, out_valid, smoothed == 16'd0 || bar_pixels == 8'd0,
    "smoothed and bar height both nonzero")

  // The store clearing pass blocks input right after reset.
  `SPSB_ASSERT_SAME(a_clear_block, $fell(rst), !in_ready, "input accepted during store clear")

  // Only one item is worked at a time.
  `SPSB_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule

bind spectrum_peak_smoother_bar_mapper_unit spsb_checker u_chk (.*);
